>>> hw/rtl/all_pkg.sv
package all_pkg;

  localparam int MAX_ENTRIES_DEF = 16;  // data slots behind the sentinel
  localparam int LIMIT_W         = 5;   // entry_limit register
  localparam int LEN_W           = 5;   // length result field
  localparam int VALUE_W         = 32;
  localparam int POS_W           = 4;
  localparam int STEPS_W         = POS_W + 1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // microprogram address
  typedef logic [3:0] step_t;

  localparam step_t S_IDLE     = 4'd0;
  localparam step_t S_DISPATCH = 4'd1;
  localparam step_t S_APP_CHK  = 4'd2;
  localparam step_t S_APP_WALK = 4'd3;
  localparam step_t S_APP_SCAN = 4'd4;
  localparam step_t S_APP_LINK = 4'd5;
  localparam step_t S_DEL_CHK  = 4'd6;
  localparam step_t S_DEL_WALK = 4'd7;
  localparam step_t S_DEL_END  = 4'd8;
  localparam step_t S_DONE     = 4'd9;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_DELETE,
    C_FULL,
    C_AT_TAIL,
    C_SLOT_FREE,
    C_EMPTY,
    C_WALK_STOP,
    C_DEL_BAD,
    C_OUT_FREE
  } cond_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_HOP,
    OP_SCAN_NEXT,
    OP_APPEND,
    OP_DEL_HOP,
    OP_UNLINK,
    OP_EMIT
  } op_t;

  // one control word: test a condition, then take the true or false arm
  typedef struct packed {
    cond_t cond;
    op_t   op_true;
    step_t step_true;
    op_t   op_false;
    step_t step_false;
  } ucw_t;

  function automatic ucw_t ucode(input step_t step);
    ucw_t w;
    unique case (step)
      S_IDLE:     w = '{C_IN_VALID,  OP_ACCEPT, S_DISPATCH, OP_NONE,      S_IDLE};
      S_DISPATCH: w = '{C_DELETE,    OP_NONE,   S_DEL_CHK,  OP_NONE,      S_APP_CHK};
      S_APP_CHK:  w = '{C_FULL,      OP_NONE,   S_DONE,     OP_NONE,      S_APP_WALK};
      S_APP_WALK: w = '{C_AT_TAIL,   OP_NONE,   S_APP_SCAN, OP_HOP,       S_APP_WALK};
      S_APP_SCAN: w = '{C_SLOT_FREE, OP_NONE,   S_APP_LINK, OP_SCAN_NEXT, S_APP_SCAN};
      S_APP_LINK: w = '{C_ALWAYS,    OP_APPEND, S_DONE,     OP_APPEND,    S_DONE};
      S_DEL_CHK:  w = '{C_EMPTY,     OP_NONE,   S_DONE,     OP_NONE,      S_DEL_WALK};
      S_DEL_WALK: w = '{C_WALK_STOP, OP_NONE,   S_DEL_END,  OP_DEL_HOP,   S_DEL_WALK};
      S_DEL_END:  w = '{C_DEL_BAD,   OP_NONE,   S_DONE,     OP_UNLINK,    S_DONE};
      S_DONE:     w = '{C_OUT_FREE,  OP_EMIT,   S_IDLE,     OP_NONE,      S_DONE};
      default:    w = '{C_ALWAYS,    OP_NONE,   S_IDLE,     OP_NONE,      S_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/all_ram.sv
module all_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/array_linked_list.sv
// Append: walk to the tail, scan for the lowest free slot, link it in; refused when full
//   after the full check.
// Delete: walk to the position or the tail, unlink; refused when empty after the empty check.
// One transaction in flight, next request taken from the cycle the result shows; the
//   link walk (one hop a cycle on the link RAM read port) and the free scan set the time.
// Reset (rst, synchronous): list empty, limit 16, no clearing pass.
module array_linked_list #(
  parameter int MAX_ENTRIES = all_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: entry_limit
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] value, [35:32] position, [39:36] zero
  input  logic [0:0]  s_tuser,   // [0] action: 0 append, 1 delete
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] ok, [5:1] length, [7:6] zero
);

  // slot index / count width, and a common width for the limit compare
  localparam int SW  = $clog2(MAX_ENTRIES + 1);
  localparam int EW  = (SW > all_pkg::LIMIT_W) ? SW : all_pkg::LIMIT_W;
  localparam int VAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  logic [all_pkg::LIMIT_W-1:0] entry_limit;
  all_pkg::step_t              upc, upc_next;

  // slot flags: bit 0 is the head sentinel
  logic [MAX_ENTRIES:0]        used;
  logic [MAX_ENTRIES:0]        tail;
  logic [SW-1:0]               count;

  // walk datapath
  logic [SW-1:0]               n, n_next;   // current node
  logic [SW-1:0]               prev;        // node before n (delete)
  logic [SW-1:0]               scan;        // free-slot scan, ends as the new slot
  logic [all_pkg::STEPS_W-1:0] steps;       // hops taken (delete)

  // latched request
  logic                        action;
  logic [all_pkg::VALUE_W-1:0] value;
  logic [all_pkg::POS_W-1:0]   position;
  logic                        ok;

  // ---------------------------------------------------------------------
  // Link RAM: the read is registered at the edge that loads n from n_next,
  // so rd_data holds the link of the registered node n unless that link was just written.
  // Tail links are never followed, so a new tail's link is left alone.
  // ---------------------------------------------------------------------
  logic          link_we;
  logic [SW-1:0] link_waddr, link_wdata, link_rdata;

  all_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_ENTRIES + 1)
  ) u_link_ram (
    .clk     (clk),
    .we      (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata),
    .rd_addr (n_next),
    .rd_data (link_rdata)
  );

  // value store: slot s held at s-1, written on append only
  logic           val_we;
  logic [VAW-1:0] val_waddr;

  all_ram #(
    .WIDTH (all_pkg::VALUE_W),
    .DEPTH (MAX_ENTRIES)
  ) u_value_ram (
    .clk     (clk),
    .we      (val_we),
    .wr_addr (val_waddr),
    .wr_data (value),
    .rd_addr ('0),
    .rd_data ()
  );

  // ---------------------------------------------------------------------
  // Sequencer: fetch control word, evaluate its condition, pick an arm
  // ---------------------------------------------------------------------
  all_pkg::ucw_t               cw;
  all_pkg::op_t                op;
  logic                        cond_hit;
  logic [EW-1:0]               lim;
  logic [all_pkg::STEPS_W-1:0] target;

  // limit beyond the array acts as the array size
  assign lim = (EW'(entry_limit) > EW'(MAX_ENTRIES)) ? EW'(MAX_ENTRIES) : EW'(entry_limit);
  assign target = all_pkg::STEPS_W'(position) + all_pkg::STEPS_W'(1);

  assign cw = all_pkg::ucode(upc);

  always_comb begin
    unique case (cw.cond)
      all_pkg::C_ALWAYS:    cond_hit = 1'b1;
      all_pkg::C_IN_VALID:  cond_hit = s_tvalid;
      all_pkg::C_DELETE:    cond_hit = action;
      all_pkg::C_FULL:      cond_hit = EW'(count) >= lim;
      all_pkg::C_AT_TAIL:   cond_hit = tail[n];
      // a free slot in 1..limit always exists once the full check passed
      all_pkg::C_SLOT_FREE: cond_hit = !used[scan];
      all_pkg::C_EMPTY:     cond_hit = (count == '0);
      all_pkg::C_WALK_STOP: cond_hit = (steps == target) || tail[n];
      // position past the end
      all_pkg::C_DEL_BAD:   cond_hit = (steps != target) || (n == '0);
      all_pkg::C_OUT_FREE:  cond_hit = !m_tvalid || m_tready;
      default:              cond_hit = 1'b0;
    endcase
  end

  assign op       = cond_hit ? cw.op_true   : cw.op_false;
  assign upc_next = cond_hit ? cw.step_true : cw.step_false;

  assign s_tready = (upc == all_pkg::S_IDLE);

  always_comb begin
    case (op)
      all_pkg::OP_ACCEPT:  n_next = '0;
      all_pkg::OP_HOP,
      all_pkg::OP_DEL_HOP: n_next = link_rdata;
      default:             n_next = n;
    endcase
  end

  // link and value writes
  always_comb begin
    link_we    = 1'b0;
    link_waddr = n;
    link_wdata = scan;
    case (op)
      all_pkg::OP_APPEND: begin
        link_we = 1'b1;
      end
      all_pkg::OP_UNLINK: begin
        link_we    = 1'b1;
        link_waddr = prev;
        link_wdata = link_rdata;
      end
      default: begin
      end
    endcase
  end

  assign val_we    = (op == all_pkg::OP_APPEND);
  assign val_waddr = VAW'(scan - SW'(1));

  // ---------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_limit <= all_pkg::LIMIT_RESET;
      upc         <= all_pkg::S_IDLE;
      used        <= (MAX_ENTRIES + 1)'(1);
      tail        <= (MAX_ENTRIES + 1)'(1);
      count       <= '0;
      n           <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        entry_limit <= cfg_wdata;
      end
      upc <= upc_next;
      n   <= n_next;
      // emit only fires when the output register is free or draining
      if (op == all_pkg::OP_EMIT) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (op)
        all_pkg::OP_APPEND: begin
          tail[n]    <= 1'b0;
          used[scan] <= 1'b1;
          tail[scan] <= 1'b1;
          count      <= count + SW'(1);
        end
        all_pkg::OP_UNLINK: begin
          tail[prev] <= tail[n];
          used[n]    <= 1'b0;
          tail[n]    <= 1'b0;
          count      <= count - SW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    case (op)
      all_pkg::OP_ACCEPT: begin
        action   <= s_tuser[0];
        value    <= s_tdata[31:0];
        position <= s_tdata[35:32];
        prev     <= '0;
        scan     <= SW'(1);
        steps    <= '0;
        ok       <= 1'b0;
      end
      all_pkg::OP_SCAN_NEXT: begin
        scan <= scan + SW'(1);
      end
      all_pkg::OP_DEL_HOP: begin
        prev  <= n;
        steps <= steps + all_pkg::STEPS_W'(1);
      end
      all_pkg::OP_APPEND,
      all_pkg::OP_UNLINK: begin
        ok <= 1'b1;
      end
      all_pkg::OP_EMIT: begin
        m_tdata <= {2'b00, all_pkg::LEN_W'(count), ok};
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_sentinel_used: assert property (@(posedge clk) disable iff (rst) used[0])
    else $error("head sentinel lost its used flag");

  a_one_tail: assert property (@(posedge clk) disable iff (rst) $onehot(tail))
    else $error("list does not have exactly one tail");

  a_tail_in_use: assert property (@(posedge clk) disable iff (rst) (tail & ~used) == '0)
    else $error("tail mark on a free slot");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    EW'(count) <= EW'(MAX_ENTRIES))
    else $error("element count beyond capacity");

endmodule

>>> test/tb_top.sv
module tb_top;

  // request kinds carried in s_tuser[0]
  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  localparam int SLOTS       = all_pkg::MAX_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 600000;   // far beyond the slowest legal run
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 56;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [all_pkg::LIMIT_W-1:0] cfg_wdata;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [39:0]                 s_tdata;   // [31:0] value, [35:32] position, [39:36] zero
  logic [0:0]                  s_tuser;   // [0] action
  logic                        m_tvalid;
  logic                        m_tready;
  logic [7:0]                  m_tdata;   // [0] ok, [5:1] length, [7:6] zero

  // one expected outcome per accepted request
  typedef struct packed {
    logic                      ok;
    logic [all_pkg::LEN_W-1:0] length;
  } list_result_t;

  // Shadow copy of the list: slot 0 is the head sentinel, slots 1..SLOTS carry data.
  // Values are written but never read back by the block, so they are not tracked.
  class list_scoreboard;
    int unsigned                 next_slot [SLOTS+1];
    bit                          in_use    [SLOTS+1];
    bit                          is_tail   [SLOTS+1];
    int unsigned                 count;
    logic [all_pkg::LIMIT_W-1:0] limit;
    list_result_t                awaited_q [$];
    int                          errors;

    function new();
      foreach (next_slot[i]) begin
        next_slot[i] = 0;
        in_use[i]    = (i == 0);
        is_tail[i]   = (i == 0);
      end
      count  = 0;
      limit  = all_pkg::LIMIT_RESET;
      errors = 0;
    endfunction

    function void set_limit(logic [all_pkg::LIMIT_W-1:0] v);
      limit = v;
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction

    function bit try_append();
      int unsigned cap, n, hops, s, free_slot;
      cap = (limit > SLOTS) ? SLOTS : limit;
      if (count >= cap) return 1'b0;
      n    = 0;
      hops = 0;
      // walk to the tail; a broken chain refuses the request
      while (!is_tail[n]) begin
        if (hops > SLOTS || next_slot[n] > SLOTS) return 1'b0;
        n = next_slot[n];
        hops++;
      end
      free_slot = 0;
      for (s = 1; s <= cap; s++) begin
        if (!in_use[s] && free_slot == 0) free_slot = s;
      end
      if (free_slot == 0) return 1'b0;
      next_slot[n]         = free_slot;
      is_tail[n]           = 1'b0;
      in_use[free_slot]    = 1'b1;
      is_tail[free_slot]   = 1'b1;
      next_slot[free_slot] = 0;
      count++;
      return 1'b1;
    endfunction

    function bit try_delete(int unsigned pos);
      int unsigned target, steps, n, prev;
      target = pos + 1;
      steps  = 0;
      n      = 0;
      prev   = 0;
      if (count == 0) return 1'b0;
      while (steps < target && !is_tail[n]) begin
        if (steps > SLOTS || next_slot[n] > SLOTS) return 1'b0;
        prev = n;
        n    = next_slot[n];
        steps++;
      end
      // position past the end of the list
      if (steps != target || n == 0) return 1'b0;
      next_slot[prev] = next_slot[n];
      is_tail[prev]   = is_tail[n];
      in_use[n]       = 1'b0;
      is_tail[n]      = 1'b0;
      next_slot[n]    = 0;
      count--;
      return 1'b1;
    endfunction

    function void note_request(logic act, logic [all_pkg::POS_W-1:0] pos);
      list_result_t r;
      r.ok     = (act == ACT_DELETE) ? try_delete(32'(pos)) : try_append();
      r.length = count[all_pkg::LEN_W-1:0];
      awaited_q.push_back(r);
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task check_result(logic [7:0] word);
      list_result_t exp_r;
      if (awaited_q.size() == 0) begin
        report($sformatf("result %02h with nothing outstanding", word));
        return;
      end
      exp_r = awaited_q.pop_front();
      if (word[0] !== exp_r.ok)
        report($sformatf("ok: got %b, want %b", word[0], exp_r.ok));
      if (word[5:1] !== exp_r.length)
        report($sformatf("length: got %0d, want %0d", word[5:1], exp_r.length));
      if (word[7:6] !== 2'b00)
        report($sformatf("padding bits not zero: %b", word[7:6]));
    endtask
  endclass

  list_scoreboard sb = new();
  int unsigned    cycles;
  bit             calm;         // phase with no bubbles on either side
  int             stall_left;

  array_linked_list uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Both handshakes are sampled here, on the rising edge, before the block's
  // own updates land. Results are checked ahead of new requests so the queue
  // order never hinges on event order.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (s_tvalid && s_tready) sb.note_request(s_tuser[0], s_tdata[35:32]);
    end
  end

  // bubble lengths: mostly none or short, now and then long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // result side back-pressure, changed on the falling edge
  initial begin
    int n;
    m_tready   = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        n = pick_idle();
        if (n > 0) begin
          m_tready   = 1'b0;
          stall_left = n - 1;
        end else begin
          m_tready = 1'b1;
        end
      end
    end
  end

  // one request transaction; returns on the edge that accepts it
  task automatic send_request(logic act, logic [31:0] val, logic [3:0] pos);
    int gap;
    gap = pick_idle();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      s_tdata  = 40'({$urandom, $urandom});   // noise on the bus while idle
      s_tuser  = 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {4'b0000, pos, val};
    s_tuser  = act;
    do @(posedge clk); while (!s_tready);
  endtask

  // hold off until the block has answered everything; it is idle then
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [all_pkg::LIMIT_W-1:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.set_limit(v);
  endtask

  // Mostly valid positions so deletes hit head, middle and tail; a quarter
  // use any position to land past the end.
  task automatic random_phase(int items, int append_pct);
    logic       act;
    logic [3:0] pos;
    for (int i = 0; i < items; i++) begin
      act = ($urandom_range(0, 99) < append_pct) ? ACT_APPEND : ACT_DELETE;
      if ($urandom_range(0, 3) == 0 || sb.count == 0)
        pos = 4'($urandom_range(0, 15));
      else
        pos = 4'($urandom_range(0, sb.count - 1));
      send_request(act, $urandom, pos);
    end
  endtask

  int phase_limit [PHASES] = '{16, 31, 0, 1, 20, 5, 16, 12, 3, 31, 8, 16, 2, 16};
  int phase_pct   [PHASES] = '{75, 70, 50, 60, 80, 40, 30, 65, 55, 85, 35, 70, 50, 45};

  initial begin
    cycles    = 0;
    calm      = 1'b0;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset limit, empty list refusals, extreme values, then
    // deletes past the end, in the middle, at the tail and at the head
    send_request(ACT_DELETE, 32'h0000_0000, 4'd0);
    send_request(ACT_DELETE, 32'hFFFF_FFFF, 4'd15);
    send_request(ACT_APPEND, 32'h8000_0000, 4'd0);
    send_request(ACT_APPEND, 32'h7FFF_FFFF, 4'd15);
    send_request(ACT_APPEND, 32'h0000_0000, 4'd5);
    send_request(ACT_APPEND, 32'hFFFF_FFFF, 4'd10);
    send_request(ACT_DELETE, 32'h1234_5678, 4'd15);
    send_request(ACT_DELETE, 32'h0, 4'd4);
    send_request(ACT_DELETE, 32'h0, 4'd1);
    send_request(ACT_DELETE, 32'h0, 4'd2);
    send_request(ACT_DELETE, 32'h0, 4'd0);
    send_request(ACT_DELETE, 32'h0, 4'd0);
    send_request(ACT_DELETE, 32'h0, 4'd0);

    // capacity of one: second append refused
    drain();
    write_limit(5'd1);
    send_request(ACT_APPEND, 32'hA5A5_A5A5, 4'd0);
    send_request(ACT_APPEND, 32'h5A5A_5A5A, 4'd0);
    send_request(ACT_DELETE, 32'h0, 4'd0);

    // zero capacity refuses every append
    drain();
    write_limit(5'd0);
    send_request(ACT_APPEND, 32'hDEAD_BEEF, 4'd0);

    // Random phases. Each one starts from a drained block, which is also where
    // the sender waits for every outstanding result. The list carries over, so
    // lowered limits meet a longer list; 31 and 20 exceed the slot count.
    for (int k = 0; k < PHASES; k++) begin
      drain();
      write_limit(all_pkg::LIMIT_W'(phase_limit[k]));
      calm = (k % 5 == 2);
      random_phase(PHASE_ITEMS, phase_pct[k]);
    end
    calm = 1'b0;

    drain();
    repeat (60) @(posedge clk);   // catch any stray result
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/all_pkg.sv
hw/rtl/all_ram.sv
hw/rtl/array_linked_list.sv
test/tb_top.sv
